// File: sv/bks_pkg.sv
`default_nettype none

package bks_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IN_W = 160;
    localparam int IN_USER_W = 2;
    localparam int OUT_W = 192;

    localparam logic [63:0] MIX_C0 = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;

    localparam logic [10:0] LIMIT_RESET = 11'd1024;
    localparam logic [63:0] SEED_RESET = 64'd42;

    localparam logic CFG_SAMPLE_LIMIT = 1'b0;
    localparam logic CFG_HASH_SEED = 1'b1;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] query;
        logic [31:0] current;
        logic [31:0] neighbor;
        logic [16:0] progress;
    } entry_t;

    typedef enum logic [2:0] {
        RSEL_PARENT,
        RSEL_LEFT,
        RSEL_RIGHT,
        RSEL_ROOT,
        RSEL_SLOT
    } rsel_t;

    typedef enum logic [1:0] {
        WSEL_NEW,
        WSEL_RDQ,
        WSEL_PICK
    } wsel_t;

    typedef struct packed {
        logic  load;
        logic  hash_start;
        logic  hole_from_fill;
        logic  hole_to_root;
        logic  hole_to_parent;
        logic  hole_to_pick;
        logic  rd_en;
        rsel_t rsel;
        logic  we;
        wsel_t wsel;
        logic  pick_left;
        logic  pick_right;
        logic  fill_inc;
        logic  set_taken;
        logic  capture_read;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic geo;
        logic lim_zero;
        logic fill_lt_lim;
        logic hash_done;
        logic hole_zero;
        logic rd_lt_key;
        logic key_lt_rd;
        logic left_ge_fill;
        logic right_lt_fill;
        logic pick_lt_rd;
        logic key_lt_pick;
        logic slot_lt_fill;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/bks_hash.sv
`default_nettype none

module bks_hash
    import bks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] seed,
    input  wire logic [31:0] query_num,
    input  wire logic [31:0] record_index,
    output logic             done,
    output logic [63:0]      key
);

    logic [3:0]  step_reg, step_next;
    logic [1:0]  which_reg, which_next;
    logic        busy_reg, busy_next;
    logic        done_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] mc;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    always_comb
    begin
        unique case (which_reg)
            2'd0:    x = {32'd0, query_num};
            2'd1:    x = {32'd0, record_index};
            default: x = acc_reg;
        endcase
        t = x + MIX_C0;
        m = p0_reg + {p1_reg + p2_reg, 32'd0};
        r = m ^ (m >> 31);
        mc = (step_reg < 4'd4) ? MIX_C1 : MIX_C2;
        unique case (step_reg)
            4'd2, 4'd6:
            begin
                mul_a = v_reg[63:32];
                mul_b = mc[31:0];
            end
            4'd3, 4'd7:
            begin
                mul_a = v_reg[31:0];
                mul_b = mc[63:32];
            end
            default:
            begin
                mul_a = v_reg[31:0];
                mul_b = mc[31:0];
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb
    begin
        step_next = step_reg;
        which_next = which_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next = v_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        acc_next = acc_reg;
        key_next = key_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            which_next = 2'd0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 4'd1;
            unique case (step_reg)
                4'd0:             v_next = t ^ (t >> 30);
                4'd1, 4'd5:       p0_next = mul_p;
                4'd2, 4'd6:       p1_next = mul_p[31:0];
                4'd3, 4'd7:       p2_next = mul_p[31:0];
                4'd4:             v_next = m ^ (m >> 27);
                default:
                begin
                    step_next = 4'd0;
                    which_next = which_reg + 2'd1;
                    unique case (which_reg)
                        2'd0:    acc_next = seed ^ r;
                        2'd1:    acc_next = acc_reg ^ r;
                        default:
                        begin
                            key_next = r;
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
            which_reg <= 2'd0;
            busy_reg <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            which_reg <= which_next;
            busy_reg <= busy_next;
            done <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        acc_reg <= acc_next;
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

`default_nettype wire

// File: sv/bks_ctrl.sv
`default_nettype none

module bks_ctrl
    import bks_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH_GO,
        S_HASH_WAIT,
        S_INS_CHECK,
        S_INS_WAIT,
        S_INS_NEW,
        S_TOP_WAIT,
        S_REP_CHECK,
        S_REP_LEFT,
        S_REP_RIGHT,
        S_REP_CMP,
        S_REP_NEW,
        S_RD_REQ,
        S_RD_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        cmd.rsel = RSEL_PARENT;
        cmd.wsel = WSEL_NEW;
        state_next = state_reg;
        s_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_HASH_GO;
                end
            S_HASH_GO:
                if (sts.is_read)
                    state_next = S_RD_REQ;
                else
                begin
                    cmd.hash_start = 1'b1;
                    state_next = S_HASH_WAIT;
                end
            S_HASH_WAIT:
                if (sts.hash_done)
                begin
                    priority if (!sts.geo || sts.lim_zero)
                        state_next = S_OUT;
                    else if (sts.fill_lt_lim)
                    begin
                        cmd.hole_from_fill = 1'b1;
                        state_next = S_INS_CHECK;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rsel = RSEL_ROOT;
                        state_next = S_TOP_WAIT;
                    end
                end
            S_INS_CHECK:
                if (sts.hole_zero)
                    state_next = S_INS_NEW;
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rsel = RSEL_PARENT;
                    state_next = S_INS_WAIT;
                end
            S_INS_WAIT:
                if (sts.rd_lt_key)
                begin
                    cmd.we = 1'b1;
                    cmd.wsel = WSEL_RDQ;
                    cmd.hole_to_parent = 1'b1;
                    state_next = S_INS_CHECK;
                end
                else
                    state_next = S_INS_NEW;
            S_INS_NEW:
            begin
                cmd.we = 1'b1;
                cmd.fill_inc = 1'b1;
                cmd.set_taken = 1'b1;
                state_next = S_OUT;
            end
            S_TOP_WAIT:
                if (sts.key_lt_rd)
                begin
                    cmd.hole_to_root = 1'b1;
                    state_next = S_REP_CHECK;
                end
                else
                    state_next = S_OUT;
            S_REP_CHECK:
                if (sts.left_ge_fill)
                    state_next = S_REP_NEW;
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rsel = RSEL_LEFT;
                    state_next = S_REP_LEFT;
                end
            S_REP_LEFT:
            begin
                cmd.pick_left = 1'b1;
                if (sts.right_lt_fill)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rsel = RSEL_RIGHT;
                    state_next = S_REP_RIGHT;
                end
                else
                    state_next = S_REP_CMP;
            end
            S_REP_RIGHT:
            begin
                cmd.pick_right = sts.pick_lt_rd;
                state_next = S_REP_CMP;
            end
            S_REP_CMP:
                if (sts.key_lt_pick)
                begin
                    cmd.we = 1'b1;
                    cmd.wsel = WSEL_PICK;
                    cmd.hole_to_pick = 1'b1;
                    state_next = S_REP_CHECK;
                end
                else
                    state_next = S_REP_NEW;
            S_REP_NEW:
            begin
                cmd.we = 1'b1;
                cmd.set_taken = 1'b1;
                state_next = S_OUT;
            end
            S_RD_REQ:
                if (sts.slot_lt_fill)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rsel = RSEL_SLOT;
                    state_next = S_RD_WAIT;
                end
                else
                    state_next = S_OUT;
            S_RD_WAIT:
            begin
                cmd.capture_read = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: sv/bks_dp.sv
`default_nettype none

module bks_dp
    import bks_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [IN_W-1:0]      s_tdata,
    input  wire logic [IN_USER_W-1:0] s_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_index,
    input  wire logic [63:0]          cfg_data,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,
    input  wire cmd_t                 cmd,
    output sts_t                      sts
);

    entry_t mem [CAPACITY];

    logic [IN_W-1:0]      item_reg;
    logic [IN_USER_W-1:0] user_reg;
    logic [10:0]          limit_reg;
    logic [63:0]          seed_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [IDX_W-1:0]     hole_reg, hole_next;
    entry_t               rd_q;
    entry_t               pick_reg;
    logic [IDX_W-1:0]     pick_idx_reg;
    logic                 taken_reg;
    logic                 valid_reg;
    entry_t               res_reg;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [31:0]      q_id;
    logic [31:0]      r_idx;
    logic [IDX_W-1:0] slot;
    logic [63:0]      key;
    logic             hash_done;
    entry_t           new_entry;
    entry_t           wdata;
    logic [CNT_W-1:0] lim;
    logic [IDX_W-1:0] parent;
    logic [IDX_W:0]   left;
    logic [IDX_W+1:0] right;
    logic [IDX_W-1:0] rd_addr;
    logic [63:0]      out_key;
    entry_t           out_entry;

    assign q_id = item_reg[31:0];
    assign r_idx = item_reg[63:32];
    assign slot = item_reg[154:145];
    assign new_entry = '{key: key, query: item_reg[31:0], current: item_reg[95:64],
                         neighbor: item_reg[127:96], progress: item_reg[144:128]};

    bks_hash u_hash (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.hash_start),
        .seed         (seed_reg),
        .query_num    (q_id),
        .record_index (r_idx),
        .done         (hash_done),
        .key          (key)
    );

    always_comb
    begin
        lim = (limit_reg > 11'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(limit_reg);
        parent = (hole_reg - IDX_W'(1)) >> 1;
        left = {hole_reg, 1'b1};
        right = {1'b0, left} + (IDX_W+2)'(1);
        unique case (cmd.rsel)
            RSEL_PARENT: rd_addr = parent;
            RSEL_LEFT:   rd_addr = left[IDX_W-1:0];
            RSEL_RIGHT:  rd_addr = right[IDX_W-1:0];
            RSEL_SLOT:   rd_addr = slot;
            default:     rd_addr = '0;
        endcase
        unique case (cmd.wsel)
            WSEL_RDQ:  wdata = rd_q;
            WSEL_PICK: wdata = pick_reg;
            default:   wdata = new_entry;
        endcase
        priority if (cmd.hole_from_fill)
            hole_next = fill_reg[IDX_W-1:0];
        else if (cmd.hole_to_root)
            hole_next = '0;
        else if (cmd.hole_to_parent)
            hole_next = parent;
        else if (cmd.hole_to_pick)
            hole_next = pick_idx_reg;
        else
            hole_next = hole_reg;
    end

    always_comb
    begin
        sts.is_read = (user_reg[0] == CMD_READ);
        sts.geo = user_reg[1];
        sts.lim_zero = (lim == '0);
        sts.fill_lt_lim = (fill_reg < lim);
        sts.hash_done = hash_done;
        sts.hole_zero = (hole_reg == '0);
        sts.rd_lt_key = (rd_q.key < key);
        sts.key_lt_rd = (key < rd_q.key);
        sts.left_ge_fill = ({1'b0, left} >= (IDX_W+2)'(fill_reg));
        sts.right_lt_fill = (right < (IDX_W+2)'(fill_reg));
        sts.pick_lt_rd = (pick_reg.key < rd_q.key);
        sts.key_lt_pick = (key < pick_reg.key);
        sts.slot_lt_fill = (CNT_W'(slot) < fill_reg);
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    always_comb
    begin
        out_entry = valid_reg ? res_reg : '0;
        priority if (valid_reg)
            out_key = res_reg.key;
        else if (user_reg[0] == CMD_OFFER)
            out_key = key;
        else
            out_key = '0;
        m_tdata_next = '0;
        m_tdata_next[0] = taken_reg;
        m_tdata_next[1] = valid_reg;
        m_tdata_next[65:2] = out_key;
        m_tdata_next[97:66] = out_entry.query;
        m_tdata_next[129:98] = out_entry.current;
        m_tdata_next[161:130] = out_entry.neighbor;
        m_tdata_next[178:162] = out_entry.progress;
        m_tdata_next[189:179] = 11'(fill_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
            mem[hole_reg] <= wdata;
        if (cmd.rd_en)
            rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= s_tdata;
            user_reg <= s_tuser;
        end
        hole_reg <= hole_next;
        if (cmd.pick_left)
        begin
            pick_reg <= rd_q;
            pick_idx_reg <= left[IDX_W-1:0];
        end
        else if (cmd.pick_right)
        begin
            pick_reg <= rd_q;
            pick_idx_reg <= right[IDX_W-1:0];
        end
        if (cmd.capture_read)
            res_reg <= rd_q;
        if (cmd.out_load)
            m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            seed_reg <= SEED_RESET;
            fill_reg <= '0;
            taken_reg <= 1'b0;
            valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_LIMIT: limit_reg <= cfg_data[10:0];
                    default:          seed_reg <= cfg_data;
                endcase
            end
            if (cmd.fill_inc)
                fill_reg <= fill_reg + CNT_W'(1);
            if (cmd.load)
            begin
                taken_reg <= 1'b0;
                valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.set_taken)
                    taken_reg <= 1'b1;
                if (cmd.capture_read)
                    valid_reg <= 1'b1;
            end
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

// File: sv/hashed_bottom_k_sampler.sv
// One word is worked on at a time; s_tready is high only while idle, so the next word can
// be taken in the cycle after the previous result is loaded into the output register.
// A read checks its slot against the count and reads a filled slot before its result is
// loaded. An offer computes its key hash (three rounds on a shared 32x32 multiplier),
// then, when the key is kept, sifts up one level per parent read and compare, or down one
// level per child check, child reads and compare. Reset clears the count at once.
`default_nettype none

module hashed_bottom_k_sampler
    import bks_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // query number, record_index, current_node, neighbor_node, progress, read_slot
    input  wire logic [IN_W-1:0]      s_tdata,
    // command, geometry_ok
    input  wire logic [IN_USER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // taken, slot_valid, hash_key, entry_query, entry_current, entry_neighbor,
    // entry_progress, stored_count
    output logic [OUT_W-1:0]          m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [63:0]          cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bks_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// File: sv/bks_checker.sv
`default_nettype none

module bks_checker
    import bks_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while the first is in progress");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[189:179] <= 11'd1024)
        else $error("stored count above capacity");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("taken and slot valid both set");

endmodule

bind hashed_bottom_k_sampler bks_checker u_bks_checker (.*);

`default_nettype wire

// File: test/tb_hashed_bottom_k_sampler.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_hashed_bottom_k_sampler;
    import bks_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        cmd;
        logic        geo;
        logic [31:0] query;
        logic [31:0] index;
        logic [31:0] current;
        logic [31:0] neighbor;
        logic [16:0] progress;
        logic [9:0]  slot;
        logic        cfg_sel;
        logic [63:0] cfg_value;
        logic        typed;
        logic        t_taken;
        logic        t_valid;
        logic [10:0] t_count;
    } row_t;

    typedef struct {
        logic        is_read;
        int          seq;
        logic        taken;
        logic        valid;
        logic [63:0] key;
        logic [10:0] count;
        logic        typed;
        logic        t_taken;
        logic        t_valid;
        logic [10:0] t_count;
    } sample_expect_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [63:0]       cfg_data;

    // Model of the sampler: a key heap of ids into a log of every entry ever kept.
    logic [63:0]    heap_key[CAPACITY];
    int             heap_id[CAPACITY];
    int             held;
    logic [10:0]    limit_reg;
    logic [63:0]    seed_reg;
    entry_t         kept_log[$];
    int             born[$];
    int             died[$];
    sample_expect_t pending[$];
    int             word_seq;
    int             errors;
    int             cycles;
    bit             calm;
    int             rx_stall;
    logic [31:0]    last_query;
    logic [31:0]    last_index;
    row_t           rows[$];

    hashed_bottom_k_sampler i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] x;
        x = v + MIX_C0;
        x = (x ^ (x >> 30)) * MIX_C1;
        x = (x ^ (x >> 27)) * MIX_C2;
        return x ^ (x >> 31);
    endfunction

    function automatic void heap_move(input int dst, input int src);
        heap_key[dst] = heap_key[src];
        heap_id[dst] = heap_id[src];
    endfunction

    function automatic void add_row(input row_t r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic void sample_offer(input logic [63:0] key, input entry_t e, input int seq,
                                         output logic taken);
        int lim;
        int hole;
        int parent;
        int left;
        int pick;
        lim = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
        taken = 1'b0;
        if (lim == 0)
            return;
        if (held < lim)
        begin
            hole = held;
            while (hole > 0)
            begin
                parent = (hole - 1) / 2;
                if (!(heap_key[parent] < key))
                    break;
                heap_move(hole, parent);
                hole = parent;
            end
            held++;
        end
        else if (held > 0 && key < heap_key[0])
        begin
            died[heap_id[0]] = seq;
            hole = 0;
            forever
            begin
                left = 2 * hole + 1;
                if (left >= held)
                    break;
                pick = left;
                if (left + 1 < held && heap_key[left] < heap_key[left + 1])
                    pick = left + 1;
                if (!(key < heap_key[pick]))
                    break;
                heap_move(hole, pick);
                hole = pick;
            end
        end
        else
            return;
        kept_log.insert(kept_log.size(), e);
        born.insert(born.size(), seq);
        died.insert(died.size(), 32'h7fffffff);
        heap_key[hole] = key;
        heap_id[hole] = kept_log.size() - 1;
        taken = 1'b1;
    endfunction

    function automatic void predict(input row_t r);
        sample_expect_t x;
        entry_t e;
        x.is_read = r.cmd;
        x.seq = word_seq;
        x.typed = r.typed;
        x.t_taken = r.t_taken;
        x.t_valid = r.t_valid;
        x.t_count = r.t_count;
        x.taken = 1'b0;
        x.valid = 1'b0;
        x.key = '0;
        if (r.cmd == CMD_OFFER)
        begin
            x.key = splitmix(seed_reg ^ splitmix({32'd0, r.query}) ^ splitmix({32'd0, r.index}));
            e = '{x.key, r.query, r.current, r.neighbor, r.progress};
            if (r.geo)
                sample_offer(x.key, e, word_seq, x.taken);
        end
        else
            x.valid = (int'(r.slot) < held);
        x.count = held[10:0];
        pending.insert(pending.size(), x);
        word_seq++;
    endfunction

    task automatic send_row(input row_t r);
        int gap;
        if (r.kind == ROW_CFG)
        begin
            s_tvalid <= 1'b0;
            while (pending.size() != 0)
                @(posedge clk);
            repeat (80) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= r.cfg_sel;
            cfg_data <= r.cfg_value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (r.cfg_sel == CFG_SAMPLE_LIMIT)
                limit_reg = r.cfg_value[10:0];
            else
                seed_reg = r.cfg_value;
            cfg_valid <= 1'b0;
            return;
        end
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {r.geo, r.cmd};
        s_tdata <= {5'd0, r.slot, r.progress, r.neighbor, r.current, r.index, r.query};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict(r);
    endtask

    function automatic row_t word_row(input logic cmd, input logic geo, input logic [31:0] q,
                                      input logic [31:0] ri, input logic [31:0] c,
                                      input logic [31:0] n, input logic [16:0] p,
                                      input logic [9:0] slot);
        row_t r;
        r = '{kind: ROW_WORD, default: '0};
        r.cmd = cmd;
        r.geo = geo;
        r.query = q;
        r.index = ri;
        r.current = c;
        r.neighbor = n;
        r.progress = p;
        r.slot = slot;
        return r;
    endfunction

    function automatic row_t typed_row(input row_t r, input logic taken, input logic valid,
                                       input logic [10:0] count);
        r.typed = 1'b1;
        r.t_taken = taken;
        r.t_valid = valid;
        r.t_count = count;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic sel, input logic [63:0] value);
        row_t r;
        r = '{kind: ROW_CFG, default: '0};
        r.cfg_sel = sel;
        r.cfg_value = value;
        return r;
    endfunction

    function automatic row_t random_row();
        row_t r;
        logic [31:0] q;
        logic [31:0] ri;
        logic [9:0] slot;
        logic [16:0] p;
        q = $urandom;
        ri = $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            q = last_query;
            ri = last_index;
        end
        last_query = q;
        last_index = ri;
        p = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        if (held > 0 && $urandom_range(0, 3) != 0)
            slot = 10'($urandom_range(0, held - 1));
        else
            slot = 10'($urandom);
        return word_row($urandom_range(0, 9) < 3 ? CMD_READ : CMD_OFFER,
                        $urandom_range(0, 9) != 0, q, ri, $urandom, $urandom, p, slot);
    endfunction

    function automatic bit alive_entry(input entry_t e, input int seq);
        for (int i = 0; i < kept_log.size(); i++)
            if (kept_log[i] == e && born[i] < seq && seq < died[i])
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic check_word(input logic [OUT_W-1:0] w);
        sample_expect_t x;
        entry_t got;
        logic [10:0] cnt;
        got = '{w[65:2], w[97:66], w[129:98], w[161:130], w[178:162]};
        cnt = w[189:179];
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, got %h", $time, w);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (x.typed && (w[0] !== x.t_taken || w[1] !== x.t_valid || cnt !== x.t_count))
        begin
            $display("%0t: taken/valid/count expected %b/%b/%0d, got %b/%b/%0d",
                     $time, x.t_taken, x.t_valid, x.t_count, w[0], w[1], cnt);
            errors++;
        end
        if (w[0] !== x.taken || w[1] !== x.valid || cnt !== x.count)
        begin
            $display("%0t: word %0d taken/valid/count expected %b/%b/%0d, got %b/%b/%0d",
                     $time, x.seq, x.taken, x.valid, x.count, w[0], w[1], cnt);
            errors++;
        end
        if (!x.is_read || !x.valid)
        begin
            if (got !== entry_t'{x.key, 32'd0, 32'd0, 32'd0, 17'd0} || w[191:190] !== 2'b00)
            begin
                $display("%0t: word %0d key/entry expected %h/0, got %h",
                         $time, x.seq, x.key, got);
                errors++;
            end
        end
        else if (!alive_entry(got, x.seq) || w[191:190] !== 2'b00)
        begin
            $display("%0t: word %0d expected a kept entry, got %h", $time, x.seq, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_word(m_tdata);
                rx_stall = calm ? 0 : $urandom_range(0, 3);
                if (rx_stall > 0)
                    m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                if (rx_stall == 0)
                    m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int limits[6];
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SAMPLE_LIMIT;
        cfg_data = '0;
        rst_n = 1'b0;
        held = 0;
        limit_reg = LIMIT_RESET;
        seed_reg = SEED_RESET;
        word_seq = 0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        last_query = '0;
        last_index = '0;

        add_row(typed_row(word_row(CMD_READ, 1, '0, '0, '0, '0, '0, 10'd0), 0, 0, 0));
        add_row(typed_row(word_row(CMD_OFFER, 1, '0, '0, '0, '0, '0, '0), 1, 0, 1));
        add_row(typed_row(word_row(CMD_OFFER, 1, '1, '1, '1, '1, 17'd65536, '1),
                          1, 0, 2));
        add_row(typed_row(word_row(CMD_OFFER, 1, 32'd7, 32'd9, 32'h5, 32'h6,
                                   17'h1ffff, '0), 1, 0, 3));
        add_row(typed_row(word_row(CMD_OFFER, 0, '1, 32'd3, '1, '1, '1, '0), 0, 0, 3));
        add_row(typed_row(word_row(CMD_READ, 0, '0, '0, '0, '0, '0, 10'd0), 0, 1, 3));
        add_row(typed_row(word_row(CMD_READ, 1, '0, '0, '0, '0, '0, 10'd2), 0, 1, 3));
        add_row(typed_row(word_row(CMD_READ, 1, '0, '0, '0, '0, '0, 10'd3), 0, 0, 3));
        add_row(typed_row(word_row(CMD_READ, 1, '0, '0, '0, '0, '0, '1), 0, 0, 3));
        add_row(typed_row(word_row(CMD_OFFER, 1, 32'haaaaaaaa, 32'h55555555,
                                   32'h55555555, 32'haaaaaaaa, 17'h0aaaa, 10'h155),
                          1, 0, 4));
        add_row(word_row(CMD_READ, 1, '0, '0, '0, '0, '0, 10'd1));
        add_row(cfg_row(CFG_SAMPLE_LIMIT, 64'd0));
        add_row(typed_row(word_row(CMD_OFFER, 1, 32'd11, 32'd12, '0, '0, '0, '0),
                          0, 0, 4));
        add_row(cfg_row(CFG_SAMPLE_LIMIT, 64'd2));
        add_row(word_row(CMD_OFFER, 1, 32'd1, 32'd2, 32'd3, 32'd4, 17'd5, '0));
        add_row(word_row(CMD_OFFER, 1, 32'd8, 32'd2, 32'd3, 32'd4, 17'd5, '0));
        add_row(cfg_row(CFG_HASH_SEED, '1));
        add_row(cfg_row(CFG_SAMPLE_LIMIT, 64'h7ff));
        add_row(word_row(CMD_OFFER, 1, 32'd1, 32'd2, 32'd3, 32'd4, 17'd5, '0));
        add_row(cfg_row(CFG_HASH_SEED, 64'd0));
        add_row(word_row(CMD_OFFER, 1, 32'd1, 32'd2, 32'd3, 32'd4, 17'd5, '0));
        add_row(word_row(CMD_READ, 1, '0, '0, '0, '0, '0, 10'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_row(rows[i]);

        limits = '{5, 0, 2047, 24, 1024, 3};
        for (int ph = 0; ph < 6; ph++)
        begin
            send_row(cfg_row(CFG_SAMPLE_LIMIT, 64'(limits[ph])));
            send_row(cfg_row(CFG_HASH_SEED, {$urandom, $urandom}));
            calm = (ph == 2);
            repeat (75) send_row(random_row());
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/bks_pkg.sv
sv/bks_hash.sv
sv/bks_ctrl.sv
sv/bks_dp.sv
sv/hashed_bottom_k_sampler.sv
sv/bks_checker.sv
test/tb_hashed_bottom_k_sampler.sv
